[hw/rtl/image_format_magic_classifier_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the image format magic classifier
// Shared property wrappers; clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMAGE_FORMAT_MAGIC_CLASSIFIER_DEFINES_SVH
`define IMAGE_FORMAT_MAGIC_CLASSIFIER_DEFINES_SVH

// Same-cycle implication
`define IMFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define IMFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/imfc_pkg.sv]
// ----------------------------------------------------------------------------
// imfc_pkg
// Types, constants and match patterns of the image format magic classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package imfc_pkg;

	localparam int HEADER_DEPTH = 17;
	localparam int SCAN_WINDOW  = 200;
	localparam int CNT_W        = 8;

	typedef logic [7:0] byte_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [2:0] prog_t;
	typedef logic [HEADER_DEPTH-1:0][7:0] hdr_t;

	typedef enum logic [3:0] {
		KIND_UNKNOWN   = 4'd0,
		KIND_JPEG      = 4'd1,
		KIND_PNG       = 4'd2,
		KIND_WEBP      = 4'd3,
		KIND_GIF       = 4'd4,
		KIND_BMP       = 4'd5,
		KIND_ICO       = 4'd6,
		KIND_TIFF      = 4'd7,
		KIND_SGI       = 4'd8,
		KIND_PSD       = 4'd9,
		KIND_PDF       = 4'd10,
		KIND_XBM       = 4'd11,
		KIND_TGA       = 4'd12,
		KIND_SVG       = 4'd13,
		KIND_TOO_SHORT = 4'd14
	} kind_t;

	// Per-body scan status handed from the scanner to the classifier
	typedef struct packed {
		cnt_t len;     // byte count including the byte being taken
		logic markup;  // svg or xml tag seen, including the byte being taken
	} scan_stat_t;

	localparam prog_t SVG_LEN = 3'd4;
	localparam prog_t XML_LEN = 3'd5;
	localparam byte_t CH_LT   = 8'h3C;

	// Characters of "<svg"
	function automatic byte_t svg_char(input prog_t p);
		byte_t c;
		unique case (p)
			3'd0:    c = 8'h3C;
			3'd1:    c = 8'h73;
			3'd2:    c = 8'h76;
			3'd3:    c = 8'h67;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Characters of "<?xml"
	function automatic byte_t xml_char(input prog_t p);
		byte_t c;
		unique case (p)
			3'd0:    c = 8'h3C;
			3'd1:    c = 8'h3F;
			3'd2:    c = 8'h78;
			3'd3:    c = 8'h6D;
			3'd4:    c = 8'h6C;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/image_format_magic_classifier.sv]
// The result appears in the output register in the cycle after the final byte is taken.
// Throughput: one byte per cycle; a new body may start the cycle after a final byte.
// Input is stalled only while a result waits in the output register and out_ready is low.
// The rate is set by the header cell chain and matchers, which update once per byte.
// Reset clears counters, matchers, fill flags and the output valid; header bytes are not
// cleared and are rewritten by each body.
// ----------------------------------------------------------------------------
// image_format_magic_classifier
// Streams file body bytes through a chain of header cells and tag matchers and
// reports the image format kind on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module image_format_magic_classifier (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire imfc_pkg::byte_t body_byte,
	input  wire logic            final_byte,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [3:0]           format_kind,
	output logic                 deferred
);
	import imfc_pkg::*;

	logic       take;
	logic       filled [HEADER_DEPTH];
	hdr_t       hdr;
	scan_stat_t stat;
	kind_t      kind;
	logic       out_valid_q;
	kind_t      kind_q;
	logic       deferred_q;

	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// Header cell chain
	for (genvar i = 0; i < HEADER_DEPTH; i++) begin : g_cell
		logic prev;
		if (i == 0) begin : g_head
			assign prev = 1'b1;
		end else begin : g_body
			assign prev = filled[i-1];
		end
		imfc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.take        (take),
			.last        (final_byte),
			.prev_filled (prev),
			.data_in     (body_byte),
			.filled      (filled[i]),
			.view        (hdr[i])
		);
	end

	imfc_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.last    (final_byte),
		.data_in (body_byte),
		.stat    (stat)
	);

	imfc_classify u_classify (
		.hdr  (hdr),
		.stat (stat),
		.kind (kind)
	);

	// Hold the result until the downstream takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && final_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (take && final_byte) begin
			kind_q     <= kind;
			deferred_q <= (kind == KIND_JPEG) || (kind == KIND_PNG) ||
				(kind == KIND_WEBP) || (kind == KIND_GIF);
		end
	end

	assign out_valid   = out_valid_q;
	assign format_kind = kind_q;
	assign deferred    = deferred_q;

endmodule

`default_nettype wire

[hw/rtl/imfc_cell.sv]
// ----------------------------------------------------------------------------
// imfc_cell
// One header byte cell. A fill flag runs down the chain: a cell captures the
// request byte when its left neighbor is filled and it is not.
// ----------------------------------------------------------------------------
`default_nettype none

module imfc_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic           last,
	input  wire logic           prev_filled,
	input  wire imfc_pkg::byte_t data_in,
	output logic                filled,
	output imfc_pkg::byte_t     view
);
	import imfc_pkg::*;

	logic  filled_q;
	byte_t byte_q;
	logic  wr;

	assign wr     = take && prev_filled && !filled_q;
	assign filled = filled_q;
	// Show the byte being written this cycle so the final byte is classified
	assign view   = wr ? data_in : byte_q;

	// Advance the fill flag; drop it at the end of a body
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= 1'b0;
		end else if (take) begin
			filled_q <= last ? 1'b0 : (filled_q | wr);
		end
	end

	// Capture the header byte
	always_ff @(posedge clk) begin
		if (wr) begin
			byte_q <= data_in;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/imfc_scan.sv]
// ----------------------------------------------------------------------------
// imfc_scan
// Saturating byte counter and case-insensitive "<svg" / "<?xml" matchers
// over the scan window, stopping at the first zero byte.
// ----------------------------------------------------------------------------
`default_nettype none

module imfc_scan (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic            last,
	input  wire imfc_pkg::byte_t data_in,
	output imfc_pkg::scan_stat_t stat
);
	import imfc_pkg::*;

	cnt_t  count_q;
	prog_t svg_q, xml_q;
	logic  zero_q, markup_q;

	prog_t svg_d, xml_d;
	logic  zero_d, markup_d;
	prog_t svg_step, xml_step;
	byte_t lc;
	logic  in_window;

	assign in_window = (count_q < cnt_t'(SCAN_WINDOW)) && !zero_q;
	assign lc = (data_in >= 8'h41 && data_in <= 8'h5A) ? (data_in + 8'h20) : data_in;

	// Step both matchers on the lower-cased byte
	always_comb begin
		svg_step = (svg_q < SVG_LEN && lc == svg_char(svg_q)) ? (svg_q + 3'd1) :
			((lc == CH_LT) ? 3'd1 : 3'd0);
		xml_step = (xml_q < XML_LEN && lc == xml_char(xml_q)) ? (xml_q + 3'd1) :
			((lc == CH_LT) ? 3'd1 : 3'd0);
		svg_d    = svg_q;
		xml_d    = xml_q;
		zero_d   = zero_q;
		markup_d = markup_q;
		if (in_window) begin
			if (data_in == 8'h00) begin
				zero_d = 1'b1;
			end else if (svg_step >= SVG_LEN || xml_step >= XML_LEN) begin
				markup_d = 1'b1;
				svg_d    = 3'd0;
				xml_d    = 3'd0;
			end else begin
				svg_d = svg_step;
				xml_d = xml_step;
			end
		end
	end

	assign stat.len    = (count_q == '1) ? count_q : (count_q + cnt_t'(1));
	assign stat.markup = markup_d;

	// Update per-body state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			svg_q    <= '0;
			xml_q    <= '0;
			zero_q   <= 1'b0;
			markup_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				count_q  <= '0;
				svg_q    <= '0;
				xml_q    <= '0;
				zero_q   <= 1'b0;
				markup_q <= 1'b0;
			end else begin
				count_q  <= stat.len;
				svg_q    <= svg_d;
				xml_q    <= xml_d;
				zero_q   <= zero_d;
				markup_q <= markup_d;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/imfc_classify.sv]
// ----------------------------------------------------------------------------
// imfc_classify
// Priority decision of the format kind from the header bytes and scan status.
// ----------------------------------------------------------------------------
`default_nettype none

module imfc_classify (
	input  wire imfc_pkg::hdr_t     hdr,
	input  wire imfc_pkg::scan_stat_t stat,
	output imfc_pkg::kind_t          kind
);
	import imfc_pkg::*;

	logic tga_depth, riff, webp, gif, pdf, psd, xbm, ico_tga, ico, tga_type;
	cnt_t len;

	assign len       = stat.len;
	assign tga_depth = (hdr[16] >= 8'd8) && (hdr[16] <= 8'd32);
	assign riff = hdr[0] == 8'h52 && hdr[1] == 8'h49 && hdr[2] == 8'h46 && hdr[3] == 8'h46;
	assign webp = hdr[8] == 8'h57 && hdr[9] == 8'h45 && hdr[10] == 8'h42 && hdr[11] == 8'h50;
	assign gif  = hdr[0] == 8'h47 && hdr[1] == 8'h49 && hdr[2] == 8'h46 && hdr[3] == 8'h38 &&
		(hdr[4] == 8'h37 || hdr[4] == 8'h39) && hdr[5] == 8'h61;
	assign psd  = hdr[0] == 8'h38 && hdr[1] == 8'h42 && hdr[2] == 8'h50 && hdr[3] == 8'h53;
	assign pdf  = hdr[0] == 8'h25 && hdr[1] == 8'h50 && hdr[2] == 8'h44 && hdr[3] == 8'h46 &&
		hdr[4] == 8'h2D;
	assign xbm  = hdr[0] == 8'h23 && hdr[1] == 8'h64 && hdr[2] == 8'h65 && hdr[3] == 8'h66 &&
		hdr[4] == 8'h69 && hdr[5] == 8'h6E && hdr[6] == 8'h65;
	// ICO header unless it reads as a TGA one
	assign ico_tga = len >= 8'd18 && hdr[2] == 8'h02 && hdr[3] == 8'h00 && tga_depth;
	assign ico  = hdr[0] == 8'h00 && hdr[1] == 8'h00 && (hdr[2] == 8'h01 || hdr[2] == 8'h02) &&
		hdr[3] == 8'h00 && !ico_tga;
	assign tga_type = hdr[2] == 8'd1 || hdr[2] == 8'd2 || hdr[2] == 8'd3 ||
		hdr[2] == 8'd9 || hdr[2] == 8'd10 || hdr[2] == 8'd11;

	// Apply the tests in priority order
	always_comb begin
		priority if (len < 8'd4) begin
			kind = KIND_TOO_SHORT;
		end else if (hdr[0] == 8'hFF && hdr[1] == 8'hD8) begin
			kind = KIND_JPEG;
		end else if (hdr[0] == 8'h89 && hdr[1] == 8'h50 && hdr[2] == 8'h4E &&
				hdr[3] == 8'h47) begin
			kind = KIND_PNG;
		end else if (len >= 8'd12 && riff && webp) begin
			kind = KIND_WEBP;
		end else if (len >= 8'd6 && gif) begin
			kind = KIND_GIF;
		end else if (hdr[0] == 8'h42 && hdr[1] == 8'h4D) begin
			kind = KIND_BMP;
		end else if (ico) begin
			kind = KIND_ICO;
		end else if ((hdr[0] == 8'h49 && hdr[1] == 8'h49 && hdr[2] == 8'h2A &&
				hdr[3] == 8'h00) || (hdr[0] == 8'h4D && hdr[1] == 8'h4D &&
				hdr[2] == 8'h00 && hdr[3] == 8'h2A)) begin
			kind = KIND_TIFF;
		end else if (len >= 8'd18 && hdr[0] == 8'h01 && hdr[1] == 8'hDA) begin
			kind = KIND_SGI;
		end else if (len >= 8'd26 && psd) begin
			kind = KIND_PSD;
		end else if (len >= 8'd5 && pdf) begin
			kind = KIND_PDF;
		end else if (len > 8'd32 && xbm) begin
			kind = KIND_XBM;
		end else if (len >= 8'd18 && (hdr[1] == 8'h00 || hdr[1] == 8'h01) && tga_type &&
				tga_depth) begin
			kind = KIND_TGA;
		end else if (stat.markup) begin
			kind = KIND_SVG;
		end else begin
			kind = KIND_UNKNOWN;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/imfc_checker.sv]
// ----------------------------------------------------------------------------
// imfc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_format_magic_classifier_defines.svh"

module imfc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] body_byte,
	input wire logic       final_byte,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] format_kind,
	input wire logic       deferred
);
	import imfc_pkg::*;

	logic heavy;
	assign heavy = format_kind == KIND_JPEG || format_kind == KIND_PNG ||
		format_kind == KIND_WEBP || format_kind == KIND_GIF;

	`IMFC_ASSERT_NOW(a_deferred_kind, out_valid, deferred == heavy, "deferred mismatch")
	`IMFC_ASSERT_NOW(a_kind_range, out_valid, format_kind <= KIND_TOO_SHORT, "bad kind code")
	`IMFC_ASSERT_NOW(a_result_cause, $rose(out_valid), $past(in_valid && in_ready && final_byte), "result without final byte")
	`IMFC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(format_kind) && $stable(deferred), "stalled result changed")

endmodule

bind image_format_magic_classifier imfc_checker u_imfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.body_byte   (body_byte),
	.final_byte  (final_byte),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.format_kind (format_kind),
	.deferred    (deferred)
);

`default_nettype wire
